// ===== rtl/core/pchipu_pkg.sv =====
// Package for the PCHIP upsampler: sizes, register indexes, controller states
// and the command word from the controller to the datapath. No dependencies.
package pchipu_pkg;

   // Sample format and derived widths.
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int MAX_BETWEEN = 30;
   localparam int PB_W        = 5;
   localparam int FT_W        = 16;
   localparam int DIFF_W      = VALUE_WIDTH + 1;
   localparam int MAG_W       = DIFF_W;
   localparam int SUM_W       = MAG_W + 1;
   localparam int PROD_W      = 2 * MAG_W;
   localparam int ACC_W       = VALUE_WIDTH + 8;
   localparam int T_W         = FRAC_BITS + 1;
   localparam int TNUM_W      = FRAC_BITS + 2;
   localparam int TDIV_W      = PB_W + 1;
   localparam int CNT_W       = $clog2(PROD_W + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = FT_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_POINTS_BETWEEN = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLAT_THRESHOLD = 1'b1;

   // Which interval is being emitted, and what follows it.
   typedef enum logic [1:0] {
      PH_LIN,
      PH_FIRST,
      PH_LAST,
      PH_END
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MPREP,
      ST_MUL,
      ST_DIV,
      ST_MDONE,
      ST_SETUP,
      ST_TDIV,
      ST_COEF,
      ST_HMUL,
      ST_HADD,
      ST_FLOAD,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_sample;
      logic       mid_init;
      logic       mul_step;
      logic       div_step;
      logic       mid_done;
      logic       setup;
      phase_type  kind;
      logic       use_end;
      logic       tdiv_step;
      logic       coef;
      logic       hmul;
      logic       hadd;
      logic [1:0] hstep;
      logic       final_load;
      logic       t_adv;
   } cmd_type;

endpackage

// ===== rtl/core/pchipu_dp.sv =====
// Datapath of the PCHIP upsampler: sample and difference windows, serial
// harmonic-mean unit, position divider and Horner evaluator. Uses pchipu_pkg.
module pchipu_dp (
   input  logic                               clock,
   input  pchipu_pkg::cmd_type                cmd,
   input  logic [pchipu_pkg::VALUE_WIDTH-1:0] sample_value,
   input  logic [pchipu_pkg::PB_W-1:0]        p,
   input  logic [pchipu_pkg::FT_W-1:0]        flat_threshold,
   output logic [pchipu_pkg::VALUE_WIDTH-1:0] out_value,
   output logic                               out_last
);
   import pchipu_pkg::*;

   // One-sided shape-preserving end slope.
   function automatic logic signed [ACC_W-1:0] end_slope(
      input logic signed [ACC_W-1:0] near,
      input logic signed [ACC_W-1:0] far
   );
      logic signed [ACC_W-1:0] n3;
      logic signed [ACC_W-1:0] v;
      logic signed [ACC_W-1:0] q;
      logic [ACC_W-1:0]        mq;
      logic [ACC_W-1:0]        mn3;
      logic                    sgn_qn;
      logic                    sgn_nf;
      n3  = near + near + near;
      v   = n3 - far;
      q   = (v + $signed(ACC_W'(v < 0))) >>> 1;
      mq  = (q < 0) ? -q : q;
      mn3 = (n3 < 0) ? -n3 : n3;
      sgn_qn = ((q < 0) != (near < 0)) || ((q == 0) != (near == 0));
      sgn_nf = ((near < 0) != (far < 0)) || ((near == 0) != (far == 0));
      if (sgn_qn) begin
         return '0;
      end else if ((mq > mn3) && sgn_nf) begin
         return n3;
      end
      return q;
   endfunction

   // Windows and slope state.
   logic signed [VALUE_WIDTH-1:0] sw0_ff, sw1_ff, sw2_ff;
   logic signed [DIFF_W-1:0]      dw0_ff, dw1_ff;
   logic signed [ACC_W-1:0]       pending_ff;
   logic signed [ACC_W-1:0]       dm_ff;

   // Harmonic-mean unit.
   logic [PROD_W-1:0] mcand_ff;
   logic [MAG_W-1:0]  mplier_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  z_ff;
   logic [SUM_W-1:0]  rem_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic              zero_ff;
   logic              neg_ff;

   // Interval and Horner registers.
   logic signed [ACC_W-1:0] y_ff, d0_ff, d1_ff, delta_ff;
   logic signed [ACC_W-1:0] c3_ff, c2_ff, acc_ff;
   logic [ACC_W+T_W-1:0]    hprod_ff;
   logic                    hneg_ff;

   // Position stepping.
   logic [TNUM_W-1:0] tnum_ff;
   logic [TDIV_W-1:0] trem_ff;
   logic [T_W-1:0]    tq_ff;
   logic [T_W-1:0]    t_ff;
   logic [TDIV_W-1:0] tr_ff;

   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic                   out_last_ff;

   // Combinational helpers.
   logic signed [ACC_W-1:0] a_ext, b_ext;
   logic [MAG_W-1:0]        ma, mb;
   logic [SUM_W:0]          div_trial;
   logic                    div_ge;
   logic [SUM_W-1:0]        q_round;
   logic [PB_W-1:0]         m_pts;
   logic [TDIV_W-1:0]       two_m;
   logic [TDIV_W:0]         t_trial;
   logic                    t_ge;
   logic [TDIV_W:0]         tr_sum;
   logic signed [ACC_W-1:0] sel_y, sel_d0, sel_d1, sel_delta;
   logic [ACC_W-1:0]        acc_mag;
   logic [ACC_W+T_W-1:0]    hround;
   logic signed [ACC_W-1:0] hterm, haddend, hsum;
   logic                    sat_ovf;
   logic [VALUE_WIDTH-1:0]  sat_val;

   // Magnitudes and trial subtractions.
   always_comb begin
      a_ext  = ACC_W'(dw0_ff);
      b_ext  = ACC_W'(dw1_ff);
      ma     = (dw0_ff < 0) ? MAG_W'(-dw0_ff) : MAG_W'(dw0_ff);
      mb     = (dw1_ff < 0) ? MAG_W'(-dw1_ff) : MAG_W'(dw1_ff);
      div_trial = {rem_ff, prod_ff[PROD_W-1]};
      div_ge    = div_trial >= {1'b0, z_ff};
      q_round   = quo_ff + SUM_W'({rem_ff, 1'b0} >= {1'b0, z_ff});
      m_pts     = p + PB_W'(1);
      two_m     = {m_pts, 1'b0};
      t_trial   = {trem_ff, tnum_ff[TNUM_W-1]};
      t_ge      = t_trial >= {1'b0, two_m};
      tr_sum    = {1'b0, tr_ff} + {1'b0, trem_ff};
   end

   // Interval endpoints and slopes by kind.
   always_comb begin
      sel_y     = ACC_W'(sw1_ff);
      sel_d0    = b_ext;
      sel_d1    = b_ext;
      sel_delta = b_ext;
      unique case (cmd.kind)
         PH_LIN: begin
            sel_y = ACC_W'(sw1_ff);
         end
         PH_FIRST: begin
            sel_y     = ACC_W'(sw0_ff);
            sel_d0    = cmd.use_end ? end_slope(a_ext, b_ext) : pending_ff;
            sel_d1    = dm_ff;
            sel_delta = a_ext;
         end
         PH_LAST: begin
            sel_d0 = dm_ff;
            sel_d1 = end_slope(b_ext, a_ext);
         end
         PH_END: begin
            sel_y = ACC_W'(sw1_ff);
         end
      endcase
   end

   // Horner step: rounded product plus coefficient, then saturation.
   always_comb begin
      acc_mag = (acc_ff < 0) ? -acc_ff : acc_ff;
      hround  = (hprod_ff + (ACC_W+T_W)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      hterm   = hneg_ff ? -ACC_W'(hround) : ACC_W'(hround);
      unique case (cmd.hstep)
         2'd0:    haddend = c2_ff;
         2'd1:    haddend = d0_ff;
         default: haddend = y_ff;
      endcase
      hsum    = haddend + hterm;
      sat_ovf = !((&hsum[ACC_W-1:VALUE_WIDTH-1]) || !(|hsum[ACC_W-1:VALUE_WIDTH-1]));
      sat_val = sat_ovf ? {hsum[ACC_W-1], {(VALUE_WIDTH-1){~hsum[ACC_W-1]}}}
                        : hsum[VALUE_WIDTH-1:0];
   end

   // Datapath registers, each updated under its command.
   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sw0_ff <= sw1_ff;
         sw1_ff <= sw2_ff;
         sw2_ff <= sample_value;
         dw0_ff <= dw1_ff;
         dw1_ff <= DIFF_W'(signed'(sample_value)) - DIFF_W'(sw2_ff);
      end
      if (cmd.mid_init) begin
         z_ff      <= SUM_W'(ma) + SUM_W'(mb);
         mcand_ff  <= PROD_W'({ma, 1'b0});
         mplier_ff <= mb;
         prod_ff   <= '0;
         rem_ff    <= '0;
         quo_ff    <= '0;
         zero_ff   <= (ma < MAG_W'(flat_threshold)) || (mb < MAG_W'(flat_threshold)) ||
                      ((dw0_ff < 0) != (dw1_ff < 0)) || (dw0_ff == 0) || (dw1_ff == 0);
         neg_ff    <= dw0_ff < 0;
      end
      if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_ff <= prod_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
      end
      if (cmd.div_step) begin
         rem_ff  <= div_ge ? SUM_W'(div_trial - {1'b0, z_ff}) : SUM_W'(div_trial);
         prod_ff <= prod_ff << 1;
         quo_ff  <= {quo_ff[SUM_W-2:0], div_ge};
      end
      if (cmd.mid_done) begin
         dm_ff <= zero_ff ? '0 : (neg_ff ? -ACC_W'(q_round) : ACC_W'(q_round));
      end
      if (cmd.setup) begin
         y_ff     <= sel_y;
         d0_ff    <= sel_d0;
         d1_ff    <= sel_d1;
         delta_ff <= sel_delta;
         if (cmd.kind == PH_FIRST) begin
            pending_ff <= dm_ff;
         end
         tnum_ff <= TNUM_W'(1) << (FRAC_BITS + 1);
         trem_ff <= '0;
         tq_ff   <= '0;
      end
      if (cmd.tdiv_step) begin
         trem_ff <= t_ge ? TDIV_W'(t_trial - {1'b0, two_m}) : TDIV_W'(t_trial);
         tnum_ff <= tnum_ff << 1;
         tq_ff   <= {tq_ff[T_W-2:0], t_ge};
      end
      if (cmd.coef) begin
         c3_ff  <= d0_ff + d1_ff - (delta_ff <<< 1);
         c2_ff  <= delta_ff + (delta_ff <<< 1) - (d0_ff <<< 1) - d1_ff;
         acc_ff <= d0_ff + d1_ff - (delta_ff <<< 1);
         t_ff   <= '0;
         tr_ff  <= TDIV_W'(m_pts);
      end
      if (cmd.hmul) begin
         hneg_ff  <= acc_ff < 0;
         hprod_ff <= acc_mag * t_ff;
      end
      if (cmd.hadd) begin
         acc_ff <= hsum;
         if (cmd.hstep == 2'd2) begin
            out_value_ff <= sat_val;
            out_last_ff  <= 1'b0;
         end
      end
      if (cmd.t_adv) begin
         acc_ff <= c3_ff;
         if (tr_sum >= {1'b0, two_m}) begin
            tr_ff <= TDIV_W'(tr_sum - {1'b0, two_m});
            t_ff  <= t_ff + tq_ff + T_W'(1);
         end else begin
            tr_ff <= TDIV_W'(tr_sum);
            t_ff  <= t_ff + tq_ff;
         end
      end
      if (cmd.final_load) begin
         out_value_ff <= sw2_ff;
         out_last_ff  <= 1'b1;
      end
   end

   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

endmodule

// ===== rtl/core/pchipu_ctrl.sv =====
// Controller of the PCHIP upsampler: sequence tracking, step counters and the
// state machine that issues datapath commands. Uses pchipu_pkg.
module pchipu_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tlast,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [pchipu_pkg::PB_W-1:0] p,
   output pchipu_pkg::cmd_type         cmd
);
   import pchipu_pkg::*;

   state_type       state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic [1:0]      seen_ff, seen_in;
   logic            last_ff, last_in;
   logic            use_end_ff, use_end_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]      hstep_ff, hstep_in;
   logic [PB_W-1:0] j_ff, j_in;

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= PH_END;
         seen_ff    <= 2'd0;
         last_ff    <= 1'b0;
         use_end_ff <= 1'b0;
         cnt_ff     <= '0;
         hstep_ff   <= 2'd0;
         j_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         seen_ff    <= seen_in;
         last_ff    <= last_in;
         use_end_ff <= use_end_in;
         cnt_ff     <= cnt_in;
         hstep_ff   <= hstep_in;
         j_ff       <= j_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      seen_in    = seen_ff;
      last_in    = last_ff;
      use_end_in = use_end_ff;
      cnt_in     = cnt_ff;
      hstep_in   = hstep_ff;
      j_in       = j_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      cmd.kind    = phase_ff;
      cmd.use_end = use_end_ff;
      cmd.hstep   = hstep_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_sample = 1'b1;
               last_in    = req_tlast;
               use_end_in = seen_ff == 2'd2;
               unique case (seen_ff)
                  2'd0: begin
                     if (req_tlast) begin
                        state_in = ST_FLOAD;
                        phase_in = PH_END;
                        seen_in  = 2'd0;
                     end else begin
                        seen_in = 2'd1;
                     end
                  end
                  2'd1: begin
                     if (req_tlast) begin
                        state_in = ST_SETUP;
                        phase_in = PH_LIN;
                        seen_in  = 2'd0;
                     end else begin
                        seen_in = 2'd2;
                     end
                  end
                  default: begin
                     state_in = ST_MPREP;
                     phase_in = PH_FIRST;
                     seen_in  = req_tlast ? 2'd0 : 2'd3;
                  end
               endcase
            end
         end
         ST_MPREP: begin
            cmd.mid_init = 1'b1;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_MDONE;
            end
         end
         ST_MDONE: begin
            cmd.mid_done = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in   = '0;
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            cmd.tdiv_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TNUM_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            cmd.coef = 1'b1;
            j_in     = '0;
            hstep_in = 2'd0;
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            cmd.hmul = 1'b1;
            state_in = ST_HADD;
         end
         ST_HADD: begin
            cmd.hadd = 1'b1;
            if (hstep_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               hstep_in = hstep_ff + 2'd1;
               state_in = ST_HMUL;
            end
         end
         ST_FLOAD: begin
            cmd.final_load = 1'b1;
            phase_in = PH_END;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (phase_ff == PH_END) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.t_adv = 1'b1;
                  hstep_in  = 2'd0;
                  if (j_ff == p) begin
                     unique case (phase_ff)
                        PH_LIN, PH_LAST: begin
                           state_in = ST_FLOAD;
                        end
                        PH_FIRST: begin
                           if (last_ff) begin
                              phase_in = PH_LAST;
                              state_in = ST_SETUP;
                           end else begin
                              state_in = ST_IDLE;
                           end
                        end
                        PH_END: begin
                           state_in = ST_IDLE;
                        end
                     endcase
                  end else begin
                     j_in     = j_ff + PB_W'(1);
                     state_in = ST_HMUL;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // A stalled result keeps the block in the output state.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_tready) |=> state_ff == ST_OUT)
      else $error("output state left while the word was stalled");

   // The last sample of a sequence returns the sequence tracker to empty.
   a_seq_end: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> seen_ff == 2'd0)
      else $error("sequence count not cleared after the last sample");

   // Horner step counter stays within the three steps.
   a_hstep: assert property (@(posedge clock) disable iff (reset)
      hstep_ff != 2'd3)
      else $error("Horner step counter out of range");

   // The point index never passes the number of points in an interval.
   a_point_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HMUL) |-> j_ff <= p)
      else $error("point index beyond the interval");
`endif

endmodule

// ===== rtl/core/pchip_upsampler_core.sv =====
// Top level of the PCHIP upsampler: configuration registers, controller and
// datapath. Uses pchipu_pkg, pchipu_ctrl and pchipu_dp.
//
// Takes one Q16.16 sample per word and emits points_between+1 interpolated
// points per interval, with points_between limited to 30, then the final
// sample with rsp_tlast set. One sample is worked on at a time. The first
// sample of a sequence is only loaded, and so is the second unless it ends the
// sequence: a lone sample is sent straight back as the final sample, and a
// closing second sample runs the position divider and one linear interval
// first. Every later sample runs the harmonic-mean slope unit (serial multiply,
// serial divide and control), then the position divider, then for each output
// point three Horner multiply and add pairs plus the output word. The last
// sample adds a second interval and then the final sample. The serial divider
// and the shared Horner multiplier set the pace.
module pchip_upsampler_core (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: sample_value[31:0]
   input  logic [pchipu_pkg::VALUE_WIDTH-1:0] req_tdata,
   input  logic                               req_tlast,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: out_value[31:0]
   output logic [pchipu_pkg::VALUE_WIDTH-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [pchipu_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [pchipu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pchipu_pkg::*;

   logic [PB_W-1:0] points_between_ff;
   logic [FT_W-1:0] flat_threshold_ff;
   logic [PB_W-1:0] p_clamped;
   cmd_type         cmd;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         points_between_ff <= PB_W'(4);
         flat_threshold_ff <= FT_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_POINTS_BETWEEN: points_between_ff <= csr_wdata[PB_W-1:0];
            CSR_FLAT_THRESHOLD: flat_threshold_ff <= csr_wdata[FT_W-1:0];
         endcase
      end
   end

   // Points per interval are limited so a step gives at most 63 words.
   assign p_clamped = (points_between_ff > PB_W'(MAX_BETWEEN)) ? PB_W'(MAX_BETWEEN)
                                                              : points_between_ff;

   pchipu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .p          (p_clamped),
      .cmd        (cmd)
   );

   pchipu_dp u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .sample_value   (req_tdata),
      .p              (p_clamped),
      .flat_threshold (flat_threshold_ff),
      .out_value      (rsp_tdata),
      .out_last       (rsp_tlast)
   );

endmodule

// ===== bench/pchip_upsampler_core_tb.sv =====
// Testbench for pchip_upsampler_core: streams sample sequences in, predicts
// every interpolated point in-bench and checks each output word. Needs pchipu_pkg.
module pchip_upsampler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pchipu_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 1000;

   typedef struct {
      logic [VALUE_WIDTH-1:0] value;
      bit                     last;
   } sample_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [VALUE_WIDTH-1:0]  req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [VALUE_WIDTH-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = CSR_POINTS_BETWEEN;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   pchip_upsampler_core i_dut (.*);

   always #5 clock = ~clock;

   // Stimulus, expectations and run statistics.
   sample_word_type  pending_samples[$];
   sample_word_type  expected_points[$];
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            error_count = 0;
   int            samples_sent = 0;
   int            points_checked = 0;
   int            sequence_count = 0;
   int            idle_cycles = 0;

   // Predictor state: configuration copy and sliding windows.
   longint unsigned  pb_setting = 4;
   longint           ft_setting = 1;
   longint           win[3];
   longint           dwin[2];
   longint           pend_slope;
   int               seen_count;

   function automatic int sign_of(longint v);
      return (v > 0) - (v < 0);
   endfunction

   function automatic longint unsigned abs_of(longint v);
      return v < 0 ? -v : v;
   endfunction

   // round(a * t / 2^FRAC_BITS), half away from zero.
   function automatic longint scale_by_t(longint a, longint unsigned t);
      longint unsigned m, r;
      m = abs_of(a);
      r = (m >> FRAC_BITS) * t
          + (((m & ((64'd1 << FRAC_BITS) - 1)) * t + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      return a < 0 ? -longint'(r) : longint'(r);
   endfunction

   // One-sided shape-preserving slope at a sequence end.
   function automatic longint edge_slope(longint near_d, longint far_d);
      longint q;
      q = (3 * near_d - far_d) / 2;
      if (sign_of(q) != sign_of(near_d)) return 0;
      if (abs_of(q) > abs_of(3 * near_d) && sign_of(near_d) != sign_of(far_d))
         return 3 * near_d;
      return q;
   endfunction

   function automatic bit is_flat(longint d);
      return d < ft_setting && d > -ft_setting;
   endfunction

   // Harmonic mean of two differences, rounded half away from zero.
   function automatic longint harmonic_slope(longint a, longint b);
      logic [127:0] prod, z, q, r;
      if (is_flat(a) || is_flat(b) || sign_of(a) != sign_of(b) || a == 0 || b == 0)
         return 0;
      prod = 128'(2 * abs_of(a)) * 128'(abs_of(b));
      z = 128'(abs_of(a)) + 128'(abs_of(b));
      q = prod / z;
      r = prod % z;
      if (2 * r >= z) q = q + 1;
      return a < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic void push_point(longint v, bit last);
      sample_word_type w;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      w.value = v[VALUE_WIDTH-1:0];
      w.last = last;
      expected_points = {expected_points, w};
   endfunction

   // Hermite points of one interval, evaluated by Horner.
   function automatic void emit_interval(longint y, longint d0, longint d1, longint delta);
      longint unsigned p, m, t;
      longint c3, c2, acc;
      p = pb_setting > MAX_BETWEEN ? MAX_BETWEEN : pb_setting;
      m = p + 1;
      c3 = d0 + d1 - 2 * delta;
      c2 = delta - d0 - c3;
      for (longint unsigned j = 0; j <= p; j++) begin
         t = ((j << (FRAC_BITS + 1)) + m) / (2 * m);
         acc = c2 + scale_by_t(c3, t);
         acc = d0 + scale_by_t(acc, t);
         push_point(y + scale_by_t(acc, t), 1'b0);
      end
   endfunction

   function automatic void predict_sample(logic [VALUE_WIDTH-1:0] raw, bit last);
      longint s, da, db, dm;
      s = longint'($signed(raw));
      win[0] = win[1];
      win[1] = win[2];
      win[2] = s;
      dwin[0] = dwin[1];
      dwin[1] = s - win[1];
      if (seen_count == 0) begin
         if (last) push_point(s, 1'b1);
         else seen_count = 1;
      end else if (seen_count == 1) begin
         if (last) begin
            emit_interval(win[1], dwin[1], dwin[1], dwin[1]);
            push_point(s, 1'b1);
            seen_count = 0;
         end else begin
            seen_count = 2;
         end
      end else begin
         da = dwin[0];
         db = dwin[1];
         dm = harmonic_slope(da, db);
         if (seen_count == 2) pend_slope = edge_slope(da, db);
         emit_interval(win[0], pend_slope, dm, da);
         pend_slope = dm;
         if (last) begin
            emit_interval(win[1], dm, edge_slope(db, da), db);
            push_point(s, 1'b1);
            seen_count = 0;
         end else begin
            seen_count = 3;
         end
      end
   endfunction

   // Driver: predicts on each accepted word, then offers the next one.
   always @(posedge clock) begin
      sample_word_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_sample(req_tdata, req_tlast);
            samples_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_samples.pop_front();
               req_tdata <= nxt.value;
               req_tlast <= nxt.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus one long hold-off so the input backs up.
   int  hold_left = 0;
   bit  held_once = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!held_once && points_checked >= 60) begin
         held_once <= 1'b1;
         hold_left <= 1500;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // Monitor: each output word against the oldest expected point.
   always @(posedge clock) begin
      sample_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected word, actual value %h last %b",
                     $realtime, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_tdata !== want.value || rsp_tlast !== want.last) begin
               $display("%0t: point mismatch, expected value %h last %b, actual value %h last %b",
                        $realtime, want.value, want.last, rsp_tdata, rsp_tlast);
               error_count++;
            end
         end
         points_checked++;
      end
   end

   // Watchdog on cycles in which no word moves on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_POINTS_BETWEEN) pb_setting = value & 5'h1F;
      else ft_setting = value;
   endtask

   task automatic configure(int pb, int ft);
      write_reg(CSR_POINTS_BETWEEN, CSR_DATA_W'(pb));
      write_reg(CSR_FLAT_THRESHOLD, CSR_DATA_W'(ft));
   endtask

   task automatic add_sample(logic [VALUE_WIDTH-1:0] v, bit last);
      sample_word_type w;
      w.value = v;
      w.last = last;
      pending_samples = {pending_samples, w};
      if (last) sequence_count++;
   endtask

   // Random sequence: a smooth walk, full-range noise, or near-flat plateaus.
   task automatic add_sequence(int len);
      int flavor;
      longint v;
      flavor = $urandom_range(9);
      v = longint'($signed(32'($urandom))) >>> $urandom_range(16, 4);
      for (int k = 0; k < len; k++) begin
         if (flavor < 6)
            v = v + (longint'($signed(32'($urandom))) >>> $urandom_range(20, 10));
         else if (flavor < 8)
            v = longint'($signed(32'($urandom)));
         else if ($urandom_range(3) == 0)
            v = v + $signed(32'($urandom_range(4))) - 2;
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         add_sample(v[31:0], k == len - 1);
      end
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || req_tvalid || expected_points.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int pb, int ft, int count);
      int start;
      configure(pb, ft);
      start = pending_samples.size();
      while (pending_samples.size() - start < count)
         add_sequence($urandom_range(3) == 0 ? $urandom_range(2, 1) : $urandom_range(12, 3));
      drain();
   endtask

   initial begin
      win = '{0, 0, 0};
      dwin = '{0, 0};
      pend_slope = 0;
      seen_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, extremes, short sequences, flats and sign flips.
      send_idle_pct = 33;
      recv_idle_pct = 82;
      add_sample(32'h7FFF_FFFF, 1'b1);
      add_sample(32'h8000_0000, 1'b1);
      add_sample(32'h8000_0000, 1'b0);
      add_sample(32'h7FFF_FFFF, 1'b1);
      add_sample(32'h0001_0000, 1'b0);
      add_sample(32'h0003_0000, 1'b0);
      add_sample(32'h0002_0000, 1'b1);
      add_sample(32'h7FFF_FFFF, 1'b0);
      add_sample(32'h8000_0000, 1'b0);
      add_sample(32'h7FFF_FFFF, 1'b0);
      add_sample(32'h8000_0000, 1'b1);
      add_sample(32'h0000_1000, 1'b0);
      add_sample(32'h0000_1000, 1'b0);
      add_sample(32'h0000_1001, 1'b0);
      add_sample(32'h0005_0000, 1'b0);
      add_sample(32'h0009_0000, 1'b0);
      add_sample(32'h000A_0000, 1'b1);
      drain();

      // Zero threshold with exact repeats, and the clamped point count.
      configure(31, 0);
      add_sample(32'hFFFF_0000, 1'b0);
      add_sample(32'hFFFF_0000, 1'b0);
      add_sample(32'h0004_0000, 1'b0);
      add_sample(32'h0004_0000, 1'b1);
      drain();

      random_phase(0, 0, 60);
      random_phase(2, 65535, 60);
      send_idle_pct = 82;
      recv_idle_pct = 33;
      random_phase(7, $urandom_range(65535), 60);
      random_phase(1, $urandom_range(255), 60);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(30, 1, 20);
      random_phase(4, $urandom_range(4096), 110);

      $display("Sent %0d samples in %0d sequences and checked %0d points,",
               samples_sent, sequence_count, points_checked);
      $display("over point counts 0..31, thresholds 0..65535 and three stall patterns.");
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
